// File: hw/rtl/fm_tuner_frequency_controller_core_defines.svh
// ----------------------------------------------------------------------------
// fm tuner frequency controller assertion macros
// property shorthands for the core rtl file
// ----------------------------------------------------------------------------
`ifndef FM_TUNER_FREQUENCY_CONTROLLER_CORE_DEFINES_SVH
`define FM_TUNER_FREQUENCY_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define FMTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fmtc check failed");

// next-cycle implication
`define FMTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fmtc check failed");

`endif

// File: hw/rtl/fmtc_pkg.sv
// ----------------------------------------------------------------------------
// fmtc_pkg
// operation codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none
package fmtc_pkg;

  localparam int MAX_STATIONS = 64;

  localparam logic [2:0] OP_SET  = 3'd0;
  localparam logic [2:0] OP_UP   = 3'd1;
  localparam logic [2:0] OP_DOWN = 3'd2;
  localparam logic [2:0] OP_MODE = 3'd3;
  localparam logic [2:0] OP_LOAD = 3'd4;
  localparam logic [2:0] OP_MEAS = 3'd5;

  localparam logic [1:0] MODE_SMALL   = 2'd0;
  localparam logic [1:0] MODE_LARGE   = 2'd1;
  localparam logic [1:0] MODE_STATION = 2'd2;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_IF    = 2'd1;
  localparam logic [1:0] CFG_THR   = 2'd2;

  localparam logic [31:0] SET_FREQ_RST = 32'd100000000;
  localparam logic [23:0] IF_RST       = 24'd10700000;
  localparam logic [23:0] THR_RST      = 24'd2000000;
  localparam logic [31:0] STEP_SMALL   = 32'd100000;
  localparam logic [31:0] STEP_LARGE   = 32'd1000000;
  localparam logic [31:0] HZ_PER_PULSE = 32'd40000;
  // ceil(2^39 / 3125), applied to the sum shifted right by five
  localparam logic [27:0] RECIP_DECI   = 28'd175921861;
  localparam logic [15:0] RECIP_TEN    = 16'hCCCD;

  typedef logic [4:0] cmd_code_t;

  localparam cmd_code_t CMD_NONE      = 5'd0;
  localparam cmd_code_t CMD_LATCH     = 5'd1;
  localparam cmd_code_t CMD_TGT_FREQ  = 5'd2;
  localparam cmd_code_t CMD_TGT_STEP  = 5'd3;
  localparam cmd_code_t CMD_MODE      = 5'd4;
  localparam cmd_code_t CMD_LOAD      = 5'd5;
  localparam cmd_code_t CMD_MEAS      = 5'd6;
  localparam cmd_code_t CMD_LOCK      = 5'd7;
  localparam cmd_code_t CMD_NS_INIT   = 5'd8;
  localparam cmd_code_t CMD_PROBE     = 5'd9;
  localparam cmd_code_t CMD_NS_CMP    = 5'd10;
  localparam cmd_code_t CMD_PICK_EDGE = 5'd11;
  localparam cmd_code_t CMD_RD_LO     = 5'd12;
  localparam cmd_code_t CMD_RD_LOM1   = 5'd13;
  localparam cmd_code_t CMD_PICK_NEAR = 5'd14;
  localparam cmd_code_t CMD_RD_NB     = 5'd15;
  localparam cmd_code_t CMD_TGT_MEM   = 5'd16;
  localparam cmd_code_t CMD_TGT_SET   = 5'd17;
  localparam cmd_code_t CMD_EX_INIT   = 5'd18;
  localparam cmd_code_t CMD_EX_CMP    = 5'd19;
  localparam cmd_code_t CMD_DIV_INIT  = 5'd20;
  localparam cmd_code_t CMD_DIV       = 5'd21;
  localparam cmd_code_t CMD_PLL       = 5'd22;
  localparam cmd_code_t CMD_OUT       = 5'd23;

  typedef struct packed {
    cmd_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] mode;
    logic       lo_lt_hi;
    logic       lo_edge;
    logic       nb_ok;
    logic       found;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/fmtc_ctrl.sv
// ----------------------------------------------------------------------------
// fmtc_ctrl
// sequencer that walks one event through the datapath
// ----------------------------------------------------------------------------
`default_nettype none
module fmtc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  fmtc_pkg::dp_status_t status_i,
  output fmtc_pkg::ctrl_cmd_t  cmd_o,
  output logic                 done_o
);
  import fmtc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_LOCK    = 4'd2;
  localparam logic [3:0] S_NS_ADDR = 4'd3;
  localparam logic [3:0] S_NS_CMP  = 4'd4;
  localparam logic [3:0] S_NS_RLO  = 4'd5;
  localparam logic [3:0] S_NS_PICK = 4'd6;
  localparam logic [3:0] S_NB_ADDR = 4'd7;
  localparam logic [3:0] S_NB_TAKE = 4'd8;
  localparam logic [3:0] S_EX_INIT = 4'd9;
  localparam logic [3:0] S_EX_ADDR = 4'd10;
  localparam logic [3:0] S_EX_CMP  = 4'd11;
  localparam logic [3:0] S_DIV     = 4'd12;
  localparam logic [3:0] S_PLL     = 4'd13;
  localparam logic [3:0] S_OUT     = 4'd14;

  logic [3:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.code = CMD_NONE;
    done_d     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.code = CMD_LATCH;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_EX_INIT;
        case (status_i.op)
          OP_SET: cmd_o.code = CMD_TGT_FREQ;
          OP_UP, OP_DOWN: begin
            if (status_i.mode == MODE_STATION) begin
              cmd_o.code = CMD_NS_INIT;
              state_d    = S_NS_ADDR;
            end else begin
              cmd_o.code = CMD_TGT_STEP;
            end
          end
          OP_MODE: cmd_o.code = CMD_MODE;
          OP_LOAD: cmd_o.code = CMD_LOAD;
          OP_MEAS: begin
            cmd_o.code = CMD_MEAS;
            state_d    = S_LOCK;
          end
          default: cmd_o.code = CMD_NONE;
        endcase
      end
      S_LOCK: begin
        cmd_o.code = CMD_LOCK;
        state_d    = S_EX_INIT;
      end
      S_NS_ADDR: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.code = CMD_PROBE;
          state_d    = S_NS_CMP;
        end else if (status_i.lo_edge) begin
          cmd_o.code = CMD_PICK_EDGE;
          state_d    = S_NB_ADDR;
        end else begin
          cmd_o.code = CMD_RD_LO;
          state_d    = S_NS_RLO;
        end
      end
      S_NS_CMP: begin
        cmd_o.code = CMD_NS_CMP;
        state_d    = S_NS_ADDR;
      end
      S_NS_RLO: begin
        cmd_o.code = CMD_RD_LOM1;
        state_d    = S_NS_PICK;
      end
      S_NS_PICK: begin
        cmd_o.code = CMD_PICK_NEAR;
        state_d    = S_NB_ADDR;
      end
      S_NB_ADDR: begin
        if (status_i.nb_ok) begin
          cmd_o.code = CMD_RD_NB;
          state_d    = S_NB_TAKE;
        end else begin
          cmd_o.code = CMD_TGT_SET;
          state_d    = S_EX_INIT;
        end
      end
      S_NB_TAKE: begin
        cmd_o.code = CMD_TGT_MEM;
        state_d    = S_EX_INIT;
      end
      S_EX_INIT: begin
        cmd_o.code = CMD_EX_INIT;
        state_d    = S_EX_ADDR;
      end
      S_EX_ADDR: begin
        if (status_i.lo_lt_hi && !status_i.found) begin
          cmd_o.code = CMD_PROBE;
          state_d    = S_EX_CMP;
        end else begin
          cmd_o.code = CMD_DIV_INIT;
          state_d    = S_DIV;
        end
      end
      S_EX_CMP: begin
        cmd_o.code = CMD_EX_CMP;
        state_d    = S_EX_ADDR;
      end
      S_DIV: begin
        cmd_o.code = CMD_DIV;
        state_d    = S_PLL;
      end
      S_PLL: begin
        cmd_o.code = CMD_PLL;
        state_d    = S_OUT;
      end
      S_OUT: begin
        cmd_o.code = CMD_OUT;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: hw/rtl/fmtc_datapath.sv
// ----------------------------------------------------------------------------
// fmtc_datapath
// tuning state, station memory, search pointers and pll word arithmetic
// ----------------------------------------------------------------------------
`default_nettype none
module fmtc_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  fmtc_pkg::ctrl_cmd_t  cmd_i,
  output fmtc_pkg::dp_status_t status_o,
  input  wire  [2:0]           operation_i,
  input  wire  [31:0]          frequency_hz_i,
  input  wire  [5:0]           station_slot_i,
  input  wire  [16:0]          pulse_count_i,
  input  wire  [6:0]           station_count_i,
  input  wire  [23:0]          intermediate_freq_hz_i,
  input  wire  [23:0]          lock_threshold_hz_i,
  output logic [31:0]          tuned_frequency_hz_o,
  output logic [16:0]          pll_word_o,
  output logic                 pll_word_valid_o,
  output logic [1:0]           tune_mode_now_o,
  output logic                 station_found_o,
  output logic [5:0]           station_number_o,
  output logic [31:0]          measured_frequency_hz_o,
  output logic                 lock_lost_o
);
  import fmtc_pkg::*;

  localparam int IW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int CW = $clog2(MAX_STATIONS + 1);

  logic [31:0] mem_q [MAX_STATIONS];
  logic [31:0] rd_q;
  logic [IW-1:0] rd_addr;

  logic [2:0]  op_q;
  logic [31:0] freq_q;
  logic [5:0]  slot_q;
  logic [16:0] pulse_q;

  logic [31:0] set_q, tgt_q, meas_q, hold_q;
  logic [1:0]  mode_q;
  logic        lost_q, retune_q, found_q;
  logic [CW-1:0] lo_q, hi_q, k_q, idx_q;
  logic [31:0] tot_q;
  logic [15:0] quo_q;
  logic [16:0] pll_q;

  logic [CW-1:0] n_cnt, mid, lo_m1, k_p1, k_m1;
  logic          slot_ok, up_dir;
  logic [31:0]   total, diff, mag, prod;
  logic [54:0]   quot_prod;
  logic [31:0]   recip;
  logic [12:0]   tens;
  logic [3:0]    digit;

  assign n_cnt   = ({25'd0, station_count_i} > 32'(MAX_STATIONS)) ? CW'(MAX_STATIONS)
                                                                   : CW'(station_count_i);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_m1   = lo_q - CW'(1);
  assign k_p1    = k_q + CW'(1);
  assign k_m1    = k_q - CW'(1);
  assign slot_ok = ({26'd0, slot_q} < 32'(MAX_STATIONS));
  assign up_dir  = (op_q == OP_UP);
  assign total   = set_q + {8'd0, intermediate_freq_hz_i};
  assign diff    = meas_q - set_q;
  assign mag     = diff[31] ? (32'd0 - diff) : diff;
  assign prod    = {15'd0, pulse_q} * HZ_PER_PULSE;
  // sum / 100000 as (sum >> 5) / 3125 by reciprocal multiplication
  assign quot_prod = {28'd0, tot_q[31:5]} * {27'd0, RECIP_DECI};
  assign recip   = quo_q * RECIP_TEN;
  assign tens    = recip[31:19];
  assign digit   = 4'(quo_q - {tens, 3'd0} - {2'd0, tens, 1'b0});

  always_comb begin
    case (cmd_i.code)
      CMD_RD_LO:   rd_addr = lo_q[IW-1:0];
      CMD_RD_LOM1: rd_addr = lo_m1[IW-1:0];
      CMD_RD_NB:   rd_addr = up_dir ? k_p1[IW-1:0] : k_m1[IW-1:0];
      default:     rd_addr = mid[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.code == CMD_LOAD && slot_ok) begin
      mem_q[IW'(slot_q)] <= freq_q;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q  <= SET_FREQ_RST;
      mode_q <= MODE_SMALL;
      lost_q <= 1'b0;
      meas_q <= 32'd0;
    end else begin
      case (cmd_i.code)
        CMD_MODE: mode_q <= (mode_q == MODE_STATION) ? MODE_SMALL : mode_q + 2'd1;
        CMD_MEAS: meas_q <= prod - {8'd0, intermediate_freq_hz_i};
        CMD_LOCK: lost_q <= (mag > {8'd0, lock_threshold_hz_i});
        CMD_EX_INIT: begin
          if (retune_q) begin
            set_q  <= tgt_q;
            lost_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.code)
      CMD_LATCH: begin
        op_q     <= operation_i;
        freq_q   <= frequency_hz_i;
        slot_q   <= station_slot_i;
        pulse_q  <= pulse_count_i;
        retune_q <= 1'b0;
      end
      CMD_TGT_FREQ: begin
        tgt_q    <= freq_q;
        retune_q <= 1'b1;
      end
      CMD_TGT_STEP: begin
        retune_q <= 1'b1;
        if (mode_q == MODE_SMALL) begin
          tgt_q <= up_dir ? set_q + STEP_SMALL : set_q - STEP_SMALL;
        end else begin
          tgt_q <= up_dir ? set_q + STEP_LARGE : set_q - STEP_LARGE;
        end
      end
      CMD_NS_INIT: begin
        lo_q <= '0;
        hi_q <= n_cnt;
      end
      CMD_NS_CMP: begin
        if (rd_q < set_q) begin
          lo_q <= mid + CW'(1);
        end else begin
          hi_q <= mid;
        end
      end
      CMD_PICK_EDGE: k_q <= (lo_q == '0) ? '0 : lo_m1;
      CMD_RD_LOM1:   hold_q <= rd_q;
      CMD_PICK_NEAR: k_q <= ((hold_q - set_q) < (set_q - rd_q)) ? lo_q : lo_m1;
      CMD_TGT_MEM: begin
        tgt_q    <= rd_q;
        retune_q <= 1'b1;
      end
      CMD_TGT_SET: begin
        tgt_q    <= set_q;
        retune_q <= 1'b1;
      end
      CMD_EX_INIT: begin
        lo_q    <= '0;
        hi_q    <= n_cnt;
        found_q <= 1'b0;
        idx_q   <= '0;
      end
      CMD_EX_CMP: begin
        if (rd_q == set_q) begin
          found_q <= 1'b1;
          idx_q   <= mid;
        end else if (rd_q < set_q) begin
          lo_q <= mid + CW'(1);
        end else begin
          hi_q <= mid;
        end
      end
      CMD_DIV_INIT: tot_q <= total;
      CMD_DIV:      quo_q <= quot_prod[54:39];
      CMD_PLL:      pll_q <= {1'b1, 4'd0, tens[7:0], digit};
      CMD_OUT: begin
        tuned_frequency_hz_o    <= set_q;
        pll_word_o              <= retune_q ? pll_q : 17'd0;
        pll_word_valid_o        <= retune_q;
        tune_mode_now_o         <= mode_q;
        station_found_o         <= found_q;
        station_number_o        <= found_q ? 6'(idx_q) : 6'd0;
        measured_frequency_hz_o <= meas_q;
        lock_lost_o             <= lost_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.op       = op_q;
    status_o.mode     = mode_q;
    status_o.lo_lt_hi = (lo_q < hi_q);
    status_o.lo_edge  = (lo_q == '0) || (lo_q == n_cnt);
    status_o.nb_ok    = up_dir ? (k_p1 < n_cnt) : (k_q != '0);
    status_o.found    = found_q;
  end

endmodule
`default_nettype wire

// File: hw/rtl/fm_tuner_frequency_controller_core.sv
// ----------------------------------------------------------------------------
// fm tuner frequency controller core
// tuned frequency, tune mode, station table and lock supervision
// ----------------------------------------------------------------------------
// usage
//   an event word is taken when start is high and busy is low; operation
//   selects set, step up, step down, mode switch, station load or measurement
//   one result word per event appears for one cycle with done_o high
//   the result waits on the memory binary searches (one, or two for a
//   station step) and on the reciprocal multiply that forms the pll word
//   one event at a time; busy stays high until the result cycle
//   configuration writes go through cfg_valid_i, always ready; the user
//   must make them while the block is idle, which it does not enforce;
//   index 0 station count, 1 intermediate frequency, 2 lock threshold, others dropped
//   reset sets 100 MHz, 100 kHz steps, lock flag and measurement clear;
//   station entries hold nothing until loaded
//   the receiver cannot stall; results must be taken when done_o is high
// ----------------------------------------------------------------------------
`default_nettype none
module fm_tuner_frequency_controller_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  operation_i,
  input  wire  [31:0] frequency_hz_i,
  input  wire  [5:0]  station_slot_i,
  input  wire  [16:0] pulse_count_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [23:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] tuned_frequency_hz_o,
  output logic [16:0] pll_word_o,
  output logic        pll_word_valid_o,
  output logic [1:0]  tune_mode_now_o,
  output logic        station_found_o,
  output logic [5:0]  station_number_o,
  output logic [31:0] measured_frequency_hz_o,
  output logic        lock_lost_o
);
  import fmtc_pkg::*;

  `include "fm_tuner_frequency_controller_core_defines.svh"

  logic [6:0]  count_q;
  logic [23:0] if_q, thr_q;
  ctrl_cmd_t   cmd;
  dp_status_t  status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd0;
      if_q    <= IF_RST;
      thr_q   <= THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COUNT: count_q <= cfg_data_i[6:0];
        CFG_IF:    if_q    <= cfg_data_i;
        CFG_THR:   thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fmtc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd),
    .done_o   (done_o)
  );

  fmtc_datapath u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .status_o                (status),
    .operation_i             (operation_i),
    .frequency_hz_i          (frequency_hz_i),
    .station_slot_i          (station_slot_i),
    .pulse_count_i           (pulse_count_i),
    .station_count_i         (count_q),
    .intermediate_freq_hz_i  (if_q),
    .lock_threshold_hz_i     (thr_q),
    .tuned_frequency_hz_o    (tuned_frequency_hz_o),
    .pll_word_o              (pll_word_o),
    .pll_word_valid_o        (pll_word_valid_o),
    .tune_mode_now_o         (tune_mode_now_o),
    .station_found_o         (station_found_o),
    .station_number_o        (station_number_o),
    .measured_frequency_hz_o (measured_frequency_hz_o),
    .lock_lost_o             (lock_lost_o)
  );

  `FMTC_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `FMTC_ASSERT_NOW(a_done_idle, done_o, !busy)
  `FMTC_ASSERT_NOW(a_pll_marker, done_o && pll_word_valid_o, pll_word_o[16] && !lock_lost_o)
  `FMTC_ASSERT_NOW(a_pll_zero, done_o && !pll_word_valid_o, pll_word_o == 17'd0)
  `FMTC_ASSERT_NOW(a_number_zero, done_o && !station_found_o, station_number_o == 6'd0)

endmodule
`default_nettype wire

// File: verif/tb_fm_tuner_frequency_controller_core.sv
// ----------------------------------------------------------------------------
// fm tuner frequency controller core testbench
// drives event words through the start/busy handshake and the configuration
// channel; an in-bench model of tuning, station search, pll word and lock
// supervision predicts result words its row does not fix; checked in order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_fm_tuner_frequency_controller_core;
  import fmtc_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [31:0] tuned;
    logic [16:0] pll;
    logic        pll_valid;
    logic [1:0]  mode;
    logic        found;
    logic [5:0]  number;
    logic [31:0] measured;
    logic        lost;
  } tuner_result_t;

  typedef struct {
    logic [2:0]    op;
    logic [31:0]   freq;
    logic [5:0]    slot;
    logic [16:0]   pulses;
    bit            fixed_check;
    tuner_result_t fixed;
  } event_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  operation_i;
  logic [31:0] frequency_hz_i;
  logic [5:0]  station_slot_i;
  logic [16:0] pulse_count_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        done_o;
  logic [31:0] tuned_frequency_hz_o;
  logic [16:0] pll_word_o;
  logic        pll_word_valid_o;
  logic [1:0]  tune_mode_now_o;
  logic        station_found_o;
  logic [5:0]  station_number_o;
  logic [31:0] measured_frequency_hz_o;
  logic        lock_lost_o;

  fm_tuner_frequency_controller_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(operation_i), .frequency_hz_i(frequency_hz_i),
    .station_slot_i(station_slot_i), .pulse_count_i(pulse_count_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i), .done_o(done_o),
    .tuned_frequency_hz_o(tuned_frequency_hz_o), .pll_word_o(pll_word_o),
    .pll_word_valid_o(pll_word_valid_o), .tune_mode_now_o(tune_mode_now_o),
    .station_found_o(station_found_o), .station_number_o(station_number_o),
    .measured_frequency_hz_o(measured_frequency_hz_o), .lock_lost_o(lock_lost_o)
  );

  // tuner model state
  logic [6:0]  m_count;
  logic [23:0] m_if;
  logic [23:0] m_thr;
  logic [31:0] m_freq;
  logic [1:0]  m_mode;
  logic        m_lost;
  logic [31:0] m_meas;
  logic [31:0] m_table [TABLE_DEPTH];
  bit          loaded [TABLE_DEPTH];

  tuner_result_t pending_results[$];
  int  mismatches;
  int  stall_cycles;
  bit  quiet_sender;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int usable_count();
    return (m_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(m_count);
  endfunction

  function automatic int loaded_prefix();
    int k;
    k = 0;
    while (k < TABLE_DEPTH && loaded[k]) k++;
    return k;
  endfunction

  function automatic logic [16:0] pll_word_of(logic [31:0] f);
    logic [31:0] total;
    logic [31:0] mhz;
    logic [31:0] digit;
    total = f + {8'd0, m_if};
    mhz   = (total / 32'd1000000) & 32'hFF;
    digit = ((total / 32'd100000) % 32'd10) & 32'hF;
    return 17'h10000 | 17'(((mhz << 4) | digit) & 32'hFFF);
  endfunction

  function automatic int nearest_slot(logic [31:0] f);
    int n, lo, hi, mid;
    n = usable_count();
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (m_table[mid] < f) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return 0;
    if (lo == n) return lo - 1;
    if ((m_table[lo] - f) < (f - m_table[lo-1])) return lo;
    return lo - 1;
  endfunction

  function automatic bit exact_slot(logic [31:0] f, output int idx);
    int lo, hi, mid;
    lo = 0;
    hi = usable_count();
    idx = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (m_table[mid] == f) begin
        idx = mid;
        return 1'b1;
      end
      if (m_table[mid] < f) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  task automatic apply_event(input logic [2:0] op, input logic [31:0] freq,
                             input logic [5:0] slot, input logic [16:0] pulses,
                             output tuner_result_t r);
    bit retune;
    logic [31:0] target;
    logic [31:0] d;
    int k, idx;
    retune = 1'b0;
    target = 32'd0;
    case (op)
      OP_SET: begin
        target = freq;
        retune = 1'b1;
      end
      OP_UP, OP_DOWN: begin
        target = m_freq;
        if (m_mode == MODE_SMALL)
          target = (op == OP_UP) ? target + STEP_SMALL : target - STEP_SMALL;
        else if (m_mode == MODE_LARGE)
          target = (op == OP_UP) ? target + STEP_LARGE : target - STEP_LARGE;
        else begin
          k = nearest_slot(m_freq);
          if (op == OP_UP) begin
            if (k + 1 < usable_count()) target = m_table[k+1];
          end else if (k > 0) target = m_table[k-1];
        end
        retune = 1'b1;
      end
      OP_MODE: m_mode = (m_mode == MODE_STATION) ? MODE_SMALL : m_mode + 2'd1;
      OP_LOAD: m_table[slot] = freq;
      OP_MEAS: begin
        m_meas = {15'd0, pulses} * HZ_PER_PULSE - {8'd0, m_if};
        d = m_meas - m_freq;
        if (d[31]) d = 32'd0 - d;
        m_lost = d > {8'd0, m_thr};
      end
      default: ;
    endcase
    if (retune) begin
      m_freq = target;
      m_lost = 1'b0;
    end
    r.found     = exact_slot(m_freq, idx);
    r.tuned     = m_freq;
    r.pll       = retune ? pll_word_of(m_freq) : 17'd0;
    r.pll_valid = retune;
    r.mode      = m_mode;
    r.number    = 6'(idx);
    r.measured  = m_meas;
    r.lost      = m_lost;
  endtask

  task automatic send_word(input event_row_t row);
    tuner_result_t r;
    while (!quiet_sender && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= row.op;
    frequency_hz_i <= row.freq;
    station_slot_i <= row.slot;
    pulse_count_i  <= row.pulses;
    do @(posedge clk_i); while (busy);
    if (row.op == OP_LOAD) loaded[row.slot] = 1'b1;
    apply_event(row.op, row.freq, row.slot, row.pulses, r);
    pending_results.push_back(row.fixed_check ? row.fixed : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves valid high; write_done lowers it
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COUNT: m_count = data[6:0];
      CFG_IF:    m_if = data;
      CFG_THR:   m_thr = data;
      default: ;
    endcase
  endtask

  task automatic write_done();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [6:0] cnt, input logic [23:0] ifreq,
                           input logic [23:0] thr);
    write_reg(CFG_COUNT, {17'd0, cnt});
    write_reg(CFG_IF, ifreq);
    write_reg(CFG_THR, thr);
    write_done();
  endtask

  function automatic event_row_t mk(logic [2:0] op, logic [31:0] freq,
                                    logic [5:0] slot, logic [16:0] pulses);
    event_row_t row;
    row.op = op;
    row.freq = freq;
    row.slot = slot;
    row.pulses = pulses;
    row.fixed_check = 1'b0;
    row.fixed = '0;
    return row;
  endfunction

  task automatic load_sorted(input int k);
    logic [31:0] f;
    f = 32'd87500000 + 32'($urandom_range(0, 40)) * STEP_SMALL;
    for (int i = 0; i < k; i++) begin
      send_word(mk(OP_LOAD, f, 6'(i), 17'($urandom)));
      f = f + 32'($urandom_range(1, 8)) * STEP_SMALL;
      if ($urandom_range(0, 3) == 0) f = f + 32'($urandom_range(0, 99999));
    end
  endtask

  function automatic event_row_t random_word();
    int r, n;
    logic [31:0] guess;
    event_row_t row;
    r = $urandom_range(0, 99);
    n = usable_count();
    row = mk(OP_RSVD6, $urandom, 6'($urandom), 17'($urandom));
    if (r < 12) begin
      row.op = OP_SET;
      if (n > 0 && $urandom_range(0, 1) == 1) row.freq = m_table[$urandom_range(0, n-1)];
      else if ($urandom_range(0, 1) == 1)
        row.freq = 32'd87500000 + 32'($urandom_range(0, 205)) * STEP_SMALL;
    end else if (r < 47) begin
      row.op = ($urandom_range(0, 1) == 1) ? OP_UP : OP_DOWN;
    end else if (r < 55) begin
      row.op = OP_MODE;
    end else if (r < 63) begin
      row.op = OP_LOAD;
      if ($urandom_range(0, 1) == 1)
        row.freq = 32'd87500000 + 32'($urandom_range(0, 205)) * STEP_SMALL;
    end else if (r < 95) begin
      row.op = OP_MEAS;
      if ($urandom_range(0, 2) != 0) begin
        guess = (m_freq + {8'd0, m_if}) / HZ_PER_PULSE;
        guess = guess + 32'($urandom_range(0, 120)) - 32'd60;
        row.pulses = (guess > 32'h1FFFF) ? 17'($urandom) : guess[16:0];
      end
    end else begin
      row.op = ($urandom_range(0, 1) == 1) ? OP_RSVD6 : OP_RSVD7;
    end
    return row;
  endfunction

  always @(posedge clk_i) begin
    tuner_result_t got, want;
    if (rst_ni && done_o) begin
      got = '{tuned_frequency_hz_o, pll_word_o, pll_word_valid_o, tune_mode_now_o,
              station_found_o, station_number_o, measured_frequency_hz_o, lock_lost_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.tuned !== want.tuned || got.pll !== want.pll ||
            got.pll_valid !== want.pll_valid || got.mode !== want.mode ||
            got.found !== want.found || got.number !== want.number ||
            got.measured !== want.measured || got.lost !== want.lost) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    event_row_t rows[$];
    event_row_t row;
    int n;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = '0;
    frequency_hz_i = '0;
    station_slot_i = '0;
    pulse_count_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    mismatches = 0;
    quiet_sender = 1'b0;
    m_count = '0;
    m_if = IF_RST;
    m_thr = THR_RST;
    m_freq = SET_FREQ_RST;
    m_mode = MODE_SMALL;
    m_lost = 1'b0;
    m_meas = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      m_table[i] = '0;
      loaded[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // measurement right after reset, then tune to zero
    row = mk(OP_MEAS, 32'd0, 6'd0, 17'd0);
    row.fixed_check = 1'b1;
    row.fixed = '{32'd100000000, 17'd0, 1'b0, MODE_SMALL, 1'b0, 6'd0,
                  32'd4284267296, 1'b1};
    rows.push_back(row);
    row = mk(OP_SET, 32'd0, 6'd0, 17'd0);
    row.fixed_check = 1'b1;
    row.fixed = '{32'd0, 17'h100A7, 1'b1, MODE_SMALL, 1'b0, 6'd0, 32'd4284267296, 1'b0};
    rows.push_back(row);
    rows.push_back(mk(OP_DOWN, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_SET, 32'hFFFFFFFF, 6'd63, 17'h1FFFF));
    rows.push_back(mk(OP_UP, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_MODE, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_UP, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_DOWN, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_MODE, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_UP, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_DOWN, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_MODE, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_RSVD6, 32'hFFFFFFFF, 6'd63, 17'h1FFFF));
    rows.push_back(mk(OP_RSVD7, 32'd0, 6'd0, 17'd0));
    rows.push_back(mk(OP_MEAS, 32'd0, 6'd0, 17'h1FFFF));
    rows.push_back(mk(OP_SET, 32'd98000000, 6'd0, 17'd0));
    rows.push_back(mk(OP_MEAS, 32'd0, 6'd0, 17'd2717));
    rows.push_back(mk(OP_MEAS, 32'd0, 6'd0, 17'd2800));
    rows.push_back(mk(OP_SET, 32'd98000000, 6'd0, 17'd0));
    rows.push_back(mk(OP_LOAD, 32'd88000000, 6'd0, 17'd0));
    rows.push_back(mk(OP_LOAD, 32'd95500000, 6'd1, 17'd0));
    rows.push_back(mk(OP_LOAD, 32'd98000000, 6'd2, 17'd0));
    rows.push_back(mk(OP_LOAD, 32'd104300000, 6'd3, 17'd0));
    rows.push_back(mk(OP_LOAD, 32'hFFFFFFFF, 6'd63, 17'd0));
    foreach (rows[i]) send_word(rows[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(7'd4, IF_RST, THR_RST);
        1: begin
          load_sorted(TABLE_DEPTH);
          drain();
          configure(7'd64, 24'd0, 24'd0);
        end
        2: configure(7'd127, 24'hFFFFFF, 24'hFFFFFF);
        3: configure(7'd0, 24'($urandom), 24'($urandom));
        default: begin
          n = $urandom_range(1, TABLE_DEPTH);
          load_sorted(n);
          drain();
          n = $urandom_range(0, n);
          if (n > loaded_prefix()) n = loaded_prefix();
          configure(7'(n), 24'($urandom_range(9000000, 11000000)),
                    24'($urandom_range(0, 3000000)));
        end
      endcase
      for (int i = 0; i < 40; i++) begin
        quiet_sender = (ph == 4);
        send_word(random_word());
      end
      quiet_sender = 1'b0;
      // hold off until every outstanding word is back
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
